### sv/rsmt_pkg.sv
// Shared types and constants for the reference-counted status mask table.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rsmt_pkg;

    // Fixed field widths.
    localparam int STATUS_BITS = 32;
    localparam int KEY_BITS    = 64;

    // Defaults for the top-level parameters.
    localparam int ENTRIES_DEFAULT    = 16;
    localparam int COUNT_BITS_DEFAULT = 8;

    // Request opcodes. The unused code behaves as a query.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Response codes.
    localparam logic [1:0] CODE_OK        = 2'd0;
    localparam logic [1:0] CODE_NOT_FOUND = 2'd1;
    localparam logic [1:0] CODE_FULL      = 2'd2;

    // Request word.
    typedef struct packed {
        logic [1:0]             opcode;
        logic [KEY_BITS-1:0]    key;
        logic [STATUS_BITS-1:0] mask;
    } req_t;

    // Response word.
    typedef struct packed {
        logic [1:0]             code;
        logic [STATUS_BITS-1:0] aggregate;
    } rsp_t;

    // Status of a finished key search.
    typedef struct packed {
        logic done;
        logic found;
        logic free_found;
    } search_stat_t;

    // Command for one read-modify-write of a counter row.
    typedef struct packed {
        logic modify;
        logic count_down;
        logic fresh;
    } row_cmd_t;

    // Status of a finished counter row access.
    typedef struct packed {
        logic done;
        logic refs_zero;
    } row_stat_t;

endpackage

`default_nettype wire

### sv/rsmt_search.sv
// Key memory with entry valid bits and a sequential scan for a key match and a free entry.
// Depends on rsmt_pkg.
`default_nettype none

module rsmt_search #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [rsmt_pkg::KEY_BITS-1:0] key,
    input  wire logic                         alloc,
    input  wire logic [IDX_W-1:0]             alloc_idx,
    input  wire logic                         release_en,
    input  wire logic [IDX_W-1:0]             release_idx,
    output rsmt_pkg::search_stat_t            stat,
    output logic [IDX_W-1:0]                  match_idx,
    output logic [IDX_W-1:0]                  free_idx
);
    import rsmt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [KEY_BITS-1:0] key_mem [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg;

    logic                scan_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic [KEY_BITS-1:0] key_q_reg;
    logic [KEY_BITS-1:0] rd_key_reg;
    logic                cmp_vld_reg;
    logic                cmp_last_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                done_reg;
    logic                found_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    match_idx_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                cmp_valid;

    // Key memory: one write port for allocation, one registered scan read port.
    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            key_mem[alloc_idx] <= key_q_reg;
        end
        rd_key_reg <= key_mem[cnt_reg];
    end

    // Valid bit of the entry whose key is being compared.
    assign cmp_valid = valid_reg[cmp_idx_reg];

    // Valid bits, scan counter and the first-match / first-free trackers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            scan_reg       <= 1'b0;
            cnt_reg        <= '0;
            key_q_reg      <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_last_reg   <= 1'b0;
            cmp_idx_reg    <= '0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            match_idx_reg  <= '0;
            free_idx_reg   <= '0;
        end
        else
        begin
            if (alloc)
            begin
                valid_reg[alloc_idx] <= 1'b1;
            end
            if (release_en)
            begin
                valid_reg[release_idx] <= 1'b0;
            end

            // Issue one key read per cycle while scanning.
            cmp_vld_reg  <= scan_reg;
            cmp_last_reg <= scan_reg && (cnt_reg == LAST_IDX);
            cmp_idx_reg  <= cnt_reg;
            if (start)
            begin
                key_q_reg      <= key;
                scan_reg       <= 1'b1;
                cnt_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (scan_reg)
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    scan_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end

            // Compare the returned key; keep the lowest match and lowest free entry.
            if (cmp_vld_reg)
            begin
                if (cmp_valid && (rd_key_reg == key_q_reg) && !found_reg)
                begin
                    found_reg     <= 1'b1;
                    match_idx_reg <= cmp_idx_reg;
                end
                if (!cmp_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= cmp_idx_reg;
                end
            end
            done_reg <= cmp_vld_reg && cmp_last_reg;
        end
    end

    assign stat      = {done_reg, found_reg, free_found_reg};
    assign match_idx = match_idx_reg;
    assign free_idx  = free_idx_reg;

endmodule

`default_nettype wire

### sv/rsmt_rows.sv
// Counter row memory: per entry a reference count and one usage counter per status bit,
// updated by a read-modify-write. Depends on rsmt_pkg.
`default_nettype none

module rsmt_rows #(
    parameter int ENTRIES    = 16,
    parameter int IDX_W      = 4,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [IDX_W-1:0]                idx,
    input  rsmt_pkg::row_cmd_t                   cmd,
    input  wire logic [rsmt_pkg::STATUS_BITS-1:0] mask,
    output rsmt_pkg::row_stat_t                  stat,
    output logic [rsmt_pkg::STATUS_BITS-1:0]     aggregate
);
    import rsmt_pkg::*;

    // Row layout: reference count on top, then the counter of status bit j at slot j.
    localparam int ROW_W = (STATUS_BITS + 1) * COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [ROW_W-1:0]       row_mem [ENTRIES];
    logic [ROW_W-1:0]       rd_row_reg;
    logic                   busy_reg;
    logic [IDX_W-1:0]       idx_q_reg;
    row_cmd_t               cmd_q_reg;
    logic [STATUS_BITS-1:0] mask_q_reg;
    logic                   done_reg;
    logic                   refs_zero_reg;
    logic [STATUS_BITS-1:0] agg_reg;

    logic [ROW_W-1:0]       old_row;
    logic [ROW_W-1:0]       new_row;
    logic [STATUS_BITS-1:0] new_agg;

    // A freshly allocated entry starts from all-zero counters.
    assign old_row = cmd_q_reg.fresh ? '0 : rd_row_reg;

    // Saturating update of every selected counter and of the reference count.
    always_comb
    begin
        logic [COUNT_BITS-1:0] v;
        logic [COUNT_BITS-1:0] r;
        new_row = old_row;
        new_agg = '0;
        for (int j = 0; j < STATUS_BITS; j++)
        begin
            v = old_row[j*COUNT_BITS +: COUNT_BITS];
            if (cmd_q_reg.modify && mask_q_reg[j])
            begin
                if (cmd_q_reg.count_down)
                begin
                    v = (v == '0) ? v : v - 1'b1;
                end
                else
                begin
                    v = (v == CNT_MAX) ? v : v + 1'b1;
                end
            end
            new_row[j*COUNT_BITS +: COUNT_BITS] = v;
            new_agg[j] = (v != '0);
        end
        r = old_row[STATUS_BITS*COUNT_BITS +: COUNT_BITS];
        if (cmd_q_reg.modify)
        begin
            if (cmd_q_reg.count_down)
            begin
                r = (r == '0) ? r : r - 1'b1;
            end
            else
            begin
                r = (r == CNT_MAX) ? r : r + 1'b1;
            end
        end
        new_row[STATUS_BITS*COUNT_BITS +: COUNT_BITS] = r;
    end

    // Memory: read on start, write back the updated row in the next cycle if the command modifies it.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rd_row_reg <= row_mem[idx];
        end
        if (busy_reg && cmd_q_reg.modify)
        begin
            row_mem[idx_q_reg] <= new_row;
        end
    end

    // Access control and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_q_reg     <= '0;
            cmd_q_reg     <= '0;
            mask_q_reg    <= '0;
            done_reg      <= 1'b0;
            refs_zero_reg <= 1'b0;
            agg_reg       <= '0;
        end
        else
        begin
            done_reg <= busy_reg;
            if (start)
            begin
                busy_reg   <= 1'b1;
                idx_q_reg  <= idx;
                cmd_q_reg  <= cmd;
                mask_q_reg <= mask;
            end
            else if (busy_reg)
            begin
                busy_reg      <= 1'b0;
                agg_reg       <= new_agg;
                refs_zero_reg <= (new_row[STATUS_BITS*COUNT_BITS +: COUNT_BITS] == '0);
            end
        end
    end

    assign stat      = {done_reg, refs_zero_reg};
    assign aggregate = agg_reg;

endmodule

`default_nettype wire

### sv/refcounted_status_mask_table.sv
// Top level of the reference-counted status mask table: request sequencer and response register.
// Depends on rsmt_pkg, rsmt_search and rsmt_rows.
`default_nettype none

// A request word (add, delete or query of a 64-bit key with a 32-bit status mask) is taken
// when req_valid and req_ready are both high, and exactly one response word follows on rsp.
// The block works on one request at a time. The key memory is scanned one entry per cycle
// to find the matching entry and the first free one. Then, unless the request touches no
// row (a delete or query of a missing key, a full table, or a zero mask on an absent key),
// the entry's counter row is read and, for a nonzero mask, updated and written back. The
// response sits in its own register, so the next request is taken while a response waits;
// that request then holds in its last state until rsp_ready takes the older response word.
// No clearing pass runs after reset: the entry valid bits clear at once and the memories'
// contents are only used for valid entries. Each request finishes its writes before the
// next one starts, so memory accesses never overlap.
module refcounted_status_mask_table #(
    parameter int ENTRIES    = rsmt_pkg::ENTRIES_DEFAULT,
    parameter int COUNT_BITS = rsmt_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  rsmt_pkg::req_t       req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output rsmt_pkg::rsp_t       rsp
);
    import rsmt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ROW,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    req_t                   item_reg;
    logic                   srch_start_reg;
    logic                   alloc_reg;
    logic                   release_reg;
    logic                   row_start_reg;
    row_cmd_t               row_cmd_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [1:0]             code_reg;
    logic [STATUS_BITS-1:0] agg_reg;
    rsp_t                   rsp_reg;
    logic                   rsp_valid_reg;

    search_stat_t           srch_stat;
    logic [IDX_W-1:0]       match_idx;
    logic [IDX_W-1:0]       free_idx;
    row_stat_t              row_stat;
    logic [STATUS_BITS-1:0] row_agg;

    logic                   zero_mask;
    logic                   plan_row;
    logic                   plan_alloc;
    row_cmd_t               plan_cmd;
    logic [1:0]             plan_code;
    logic                   out_free;

    // Key search unit.
    rsmt_search #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (srch_start_reg),
        .key         (item_reg.key),
        .alloc       (alloc_reg),
        .alloc_idx   (idx_reg),
        .release_en  (release_reg),
        .release_idx (idx_reg),
        .stat        (srch_stat),
        .match_idx   (match_idx),
        .free_idx    (free_idx)
    );

    // Counter row unit.
    rsmt_rows #(
        .ENTRIES    (ENTRIES),
        .IDX_W      (IDX_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_rows (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (row_start_reg),
        .idx       (idx_reg),
        .cmd       (row_cmd_reg),
        .mask      (item_reg.mask),
        .stat      (row_stat),
        .aggregate (row_agg)
    );

    assign zero_mask = (item_reg.mask == '0);
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Decide what the request does once the search result is known.
    always_comb
    begin
        plan_row   = 1'b0;
        plan_alloc = 1'b0;
        plan_cmd   = '0;
        plan_code  = CODE_OK;
        unique case (item_reg.opcode)
            OP_ADD:
            begin
                if (zero_mask)
                begin
                    plan_row = srch_stat.found;
                end
                else if (srch_stat.found)
                begin
                    plan_row        = 1'b1;
                    plan_cmd.modify = 1'b1;
                end
                else if (srch_stat.free_found)
                begin
                    plan_row        = 1'b1;
                    plan_alloc      = 1'b1;
                    plan_cmd.modify = 1'b1;
                    plan_cmd.fresh  = 1'b1;
                end
                else
                begin
                    plan_code = CODE_FULL;
                end
            end
            OP_DELETE:
            begin
                if (zero_mask)
                begin
                    plan_row = srch_stat.found;
                end
                else if (srch_stat.found)
                begin
                    plan_row            = 1'b1;
                    plan_cmd.modify     = 1'b1;
                    plan_cmd.count_down = 1'b1;
                end
                else
                begin
                    plan_code = CODE_NOT_FOUND;
                end
            end
            default:
            begin
                plan_row = srch_stat.found;
                if (!srch_stat.found)
                begin
                    plan_code = CODE_NOT_FOUND;
                end
            end
        endcase
    end

    // Request sequencer and response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            item_reg       <= '0;
            srch_start_reg <= 1'b0;
            alloc_reg      <= 1'b0;
            release_reg    <= 1'b0;
            row_start_reg  <= 1'b0;
            row_cmd_reg    <= '0;
            idx_reg        <= '0;
            code_reg       <= CODE_OK;
            agg_reg        <= '0;
            rsp_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            // Single-cycle strobes to the search and row units.
            srch_start_reg <= (state_reg == ST_IDLE) && req_valid;
            alloc_reg      <= (state_reg == ST_SEARCH) && srch_stat.done && plan_alloc;
            row_start_reg  <= (state_reg == ST_SEARCH) && srch_stat.done && plan_row;
            // A delete that drops the reference count to zero frees the entry.
            release_reg    <= (state_reg == ST_ROW) && row_stat.done
                              && row_cmd_reg.count_down && row_stat.refs_zero;

            // Response valid is set when a finished request loads it and cleared when taken.
            if (state_reg == ST_FINISH && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        item_reg  <= req;
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (srch_stat.done)
                    begin
                        code_reg    <= plan_code;
                        agg_reg     <= '0;
                        row_cmd_reg <= plan_cmd;
                        idx_reg     <= plan_alloc ? free_idx : match_idx;
                        if (plan_row)
                        begin
                            state_reg <= ST_ROW;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_ROW:
                begin
                    if (row_stat.done)
                    begin
                        // A freed entry reports an empty aggregate.
                        if (row_cmd_reg.count_down && row_stat.refs_zero)
                        begin
                            agg_reg <= '0;
                        end
                        else
                        begin
                            agg_reg <= row_agg;
                        end
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        rsp_reg.code      <= code_reg;
                        rsp_reg.aggregate <= agg_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A search result only arrives while the sequencer waits for it.
    a_search_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        srch_stat.done |-> state_reg == ST_SEARCH)
        else $error("search result outside the search phase");

    // A row result only arrives while the sequencer waits for it.
    a_row_done_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        row_stat.done |-> state_reg == ST_ROW)
        else $error("row result outside the row phase");

    // A full table never reports a nonzero aggregate.
    a_full_zero_agg: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.code == CODE_FULL) |-> rsp.aggregate == '0)
        else $error("table full response with nonzero aggregate");

    // A finished request waits while the response register is still occupied.
    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && rsp_valid && !rsp_ready) |=> state_reg == ST_FINISH)
        else $error("response register overwritten while occupied");

endmodule

`default_nettype wire
